// ===== hdl/pal_pkg.sv =====
// shared types and constants for the positional array list
`default_nettype none
package pal_pkg;

    localparam int CMD_W  = 2;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_APPEND = 2'd3
    } t_cmd;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== hdl/positional_array_list_unit.sv =====
// top level: ordered list of words kept in a row of shifting cells
// o_done is registered from the accept and is high in the cycle after it
// throughput: one request per cycle unless busy; cells update in parallel
// busy is high during reset and in the first cycle after it
// reset clears the length and the result strobe; entries are not cleared
// results are shown for one cycle and cannot be stalled by the receiver
`default_nettype none
module positional_array_list_unit
    import pal_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter int WORD_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [POS_W-1:0]  i_position,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_done,
    output logic              o_ok,
    output logic [WORD_W-1:0] o_read_value,
    output logic [CNT_W-1:0]  o_count
);

    localparam int STORE_BITS = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;
    localparam int IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int USED_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (USED_W > POS_W) ? USED_W : POS_W;

    logic [USED_W-1:0]     r_used;
    logic [USED_W-1:0]     n_used;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_ok;
    logic                  n_ok;
    logic [WORD_W-1:0]     r_read;
    logic [WORD_W-1:0]     n_read;

    logic                  accept;
    t_cmd                  cmd;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      used_x;
    logic                  full;
    logic                  in_range;
    logic                  ins_range;
    t_cell_ctl             cell_ctl;
    logic [IDX_W-1:0]      cell_pos;
    logic [STORE_BITS-1:0] word;
    logic [STORE_BITS-1:0] rd_or;

    logic [STORE_BITS-1:0] w_data [CAPACITY];
    logic [STORE_BITS-1:0] w_read [CAPACITY];

    assign accept    = start && !r_busy;
    assign cmd       = t_cmd'(i_command);
    assign pos_x     = CMP_W'(i_position);
    assign used_x    = CMP_W'(r_used);
    assign full      = (r_used == USED_W'(CAPACITY));
    assign in_range  = (pos_x < used_x);
    assign ins_range = (pos_x <= used_x);
    assign word      = i_value[STORE_BITS-1:0];

    always_comb begin
        cell_ctl = '0;
        cell_pos = IDX_W'(i_position);
        n_ok     = 1'b0;
        n_used   = r_used;
        case (cmd)
            CMD_READ: begin
                n_ok = in_range;
            end
            CMD_INSERT: begin
                if (!full && ins_range) begin
                    n_ok         = 1'b1;
                    cell_ctl.ins = accept;
                    n_used       = r_used + USED_W'(1);
                end
            end
            CMD_DELETE: begin
                if (in_range) begin
                    n_ok         = 1'b1;
                    cell_ctl.del = accept;
                    n_used       = r_used - USED_W'(1);
                end
            end
            CMD_APPEND: begin
                cell_pos = IDX_W'(r_used);
                if (!full) begin
                    n_ok         = 1'b1;
                    cell_ctl.ins = accept;
                    n_used       = r_used + USED_W'(1);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | w_read[i];
        end
    end

    assign n_read = (cmd == CMD_READ && in_range) ? WORD_W'(rd_or) : '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [STORE_BITS-1:0] left;
        logic [STORE_BITS-1:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid
            assign left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = w_data[g+1];
        end
        pal_cell #(
            .W     (STORE_BITS),
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_pos   (cell_pos),
            .i_word  (word),
            .i_left  (left),
            .i_right (right),
            .o_data  (w_data[g]),
            .o_read  (w_read[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_done <= accept;
            if (accept) begin
                r_used <= n_used;
            end
        end
        if (accept) begin
            r_ok   <= n_ok;
            r_read <= n_read;
        end
    end

    assign busy         = r_busy;
    assign o_done       = r_done;
    assign o_ok         = r_ok;
    assign o_read_value = r_read;
    assign o_count      = CNT_W'(r_used);

endmodule
`default_nettype wire

// ===== hdl/pal_cell.sv =====
// one list entry: holds, takes a neighbor's word, or takes the new word
`default_nettype none
module pal_cell
    import pal_pkg::*;
#(
    parameter int W     = 32,
    parameter int IDX_W = 5,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_pos,
    input  logic [W-1:0]     i_word,
    input  logic [W-1:0]     i_left,
    input  logic [W-1:0]     i_right,
    output logic [W-1:0]     o_data,
    output logic [W-1:0]     o_read
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_data = i_left;
            end else if (MY_IDX == i_pos) begin
                n_data = i_word;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = (MY_IDX == i_pos) ? r_data : '0;

endmodule
`default_nettype wire

// ===== hdl/pal_checker.sv =====
// port-level checks for the positional array list, bound to the top level
`default_nettype none
module pal_checker
    import pal_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [CMD_W-1:0]  i_command,
    input logic              o_done,
    input logic              o_ok,
    input logic [WORD_W-1:0] o_read_value,
    input logic [CNT_W-1:0]  o_count
);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("missing result after accepted word");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> (!o_done && $stable(o_count)))
        else $error("result or count change without accepted word");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_read_value == '0 && o_count == $past(o_count)))
        else $error("rejected request changed count or returned data");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ok && ($past(i_command) == CMD_INSERT
                            || $past(i_command) == CMD_APPEND))
        |-> (o_count == CNT_W'($past(o_count) + CNT_W'(1))))
        else $error("insert did not grow the list by one");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_command    (i_command),
    .o_done       (o_done),
    .o_ok         (o_ok),
    .o_read_value (o_read_value),
    .o_count      (o_count)
);
`default_nettype wire

// ===== tb/pal_list_checker.sv =====
// checker for the positional array list: predicts each result and compares it
module pal_list_checker
    import pal_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [POS_W-1:0]  i_position,
    input  logic [WORD_W-1:0] i_value,
    input  logic              i_done,
    input  logic              i_ok,
    input  logic [WORD_W-1:0] i_read_value,
    input  logic [CNT_W-1:0]  i_count,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_list_len,
    output int                o_checked,
    output int                o_rejected,
    output int                o_peak_len
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    logic [WORD_W-1:0] list_words [CAPACITY];
    int                list_len;
    t_list_result      expected_results [$];

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_list_result apply_request(t_cmd cmd, int pos,
                                                   logic [WORD_W-1:0] word);
        t_list_result res;
        res = '0;
        case (cmd)
            CMD_READ: begin
                if (pos < list_len) begin
                    res.ok         = 1'b1;
                    res.read_value = list_words[pos];
                end
            end
            CMD_INSERT: begin
                if (list_len < CAPACITY && pos <= list_len) begin
                    for (int k = list_len; k > pos; k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            CMD_DELETE: begin
                if (pos < list_len) begin
                    for (int k = pos; k + 1 < list_len; k++)
                        list_words[k] = list_words[k+1];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (list_len < CAPACITY) begin
                    list_words[list_len] = word;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
        endcase
        res.count = CNT_W'(list_len);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word with no request pending (ok %0b)",
                                              i_ok));
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (!want.ok)
                        o_rejected++;
                    if (i_ok !== want.ok)
                        report_mismatch($sformatf("ok got %0b, expected %0b",
                                                  i_ok, want.ok));
                    if (i_read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %08h, expected %08h",
                                                  i_read_value, want.read_value));
                    if (i_count !== want.count)
                        report_mismatch($sformatf("count got %0d, expected %0d",
                                                  i_count, want.count));
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_request(t_cmd'(i_command),
                                                         int'(i_position), i_value));
        end
        o_pending  = expected_results.size();
        o_list_len = list_len;
        if (list_len > o_peak_len)
            o_peak_len = list_len;
    end

endmodule

// ===== tb/positional_array_list_unit_test.sv =====
// testbench top for the positional array list: stimulus, checker hookup and verdict
module positional_array_list_unit_test;
    import pal_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 32;
    localparam int N_ITEMS  = 1850;
    localparam int LIMIT_NS = 2_000_000;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [CMD_W-1:0]  i_command = CMD_READ;
    logic [POS_W-1:0]  i_position = '0;
    logic [WORD_W-1:0] i_value = '0;
    logic              o_done;
    logic              o_ok;
    logic [WORD_W-1:0] o_read_value;
    logic [CNT_W-1:0]  o_count;

    int fail_count;
    int pending;
    int list_len;
    int checked;
    int rejected;
    int peak_len;
    int issued = 0;
    logic no_idle = 1'b0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    positional_array_list_unit #(
        .CAPACITY (CAPACITY),
        .WORD_BITS(WORD_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_ok        (o_ok),
        .o_read_value(o_read_value),
        .o_count     (o_count)
    );

    pal_list_checker #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_done      (o_done),
        .i_ok        (o_ok),
        .i_read_value(o_read_value),
        .i_count     (o_count),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_list_len  (list_len),
        .o_checked   (checked),
        .o_rejected  (rejected),
        .o_peak_len  (peak_len)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_word(t_cmd cmd, int pos, logic [WORD_W-1:0] word, int gap);
        start      <= 1'b1;
        i_command  <= cmd;
        i_position <= POS_W'(pos);
        i_value    <= word;
        while (busy)
            @(negedge i_clk);
        @(negedge i_clk);
        issued++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic random_request(int mode);
        int   r;
        int   pos;
        t_cmd cmd;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // noise: any command at any position
            send_word(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31), pick_value(),
                      pick_gap());
        end else begin
            r = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:  cmd = r < 45 ? CMD_APPEND : r < 80 ? CMD_INSERT :
                                  r < 95 ? CMD_READ : CMD_DELETE;
                MODE_DRAIN: cmd = r < 50 ? CMD_DELETE : r < 75 ? CMD_READ :
                                  r < 90 ? CMD_INSERT : CMD_APPEND;
                default:    cmd = t_cmd'(r % 4);
            endcase
            if (cmd == CMD_INSERT)
                pos = $urandom_range(0, list_len < 31 ? list_len : 31);
            else if (list_len > 0)
                pos = $urandom_range(0, list_len - 1);
            else
                pos = 0;
            send_word(cmd, pos, pick_value(), pick_gap());
        end
    endtask

    initial begin
        int mode;
        int seg_len;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list rejections
        send_word(CMD_READ,   0,  32'h0000_0000, 0);
        send_word(CMD_DELETE, 0,  32'h0000_0000, 1);
        send_word(CMD_READ,   31, 32'hFFFF_FFFF, 0);
        send_word(CMD_DELETE, 31, 32'hFFFF_FFFF, 0);
        send_word(CMD_INSERT, 1,  32'h1234_5678, 2);
        // build a short list
        send_word(CMD_INSERT, 0,  32'hFFFF_FFFF, 0);
        send_word(CMD_APPEND, 0,  32'h0000_0000, 0);
        send_word(CMD_INSERT, 2,  32'hA5A5_A5A5, 0);
        send_word(CMD_INSERT, 0,  32'h5A5A_5A5A, 1);
        send_word(CMD_INSERT, 4,  32'h0000_0001, 0);
        send_word(CMD_INSERT, 6,  32'h8000_0000, 0);
        for (int k = 0; k < 5; k++)
            send_word(CMD_READ, k, 32'h0, 0);
        send_word(CMD_READ,   5,  32'h0, 0);
        send_word(CMD_DELETE, 5,  32'h0, 3);
        send_word(CMD_DELETE, 2,  32'h0, 0);
        send_word(CMD_DELETE, 0,  32'h0, 0);
        send_word(CMD_READ,   0,  32'h0, 0);
        send_word(CMD_APPEND, 31, 32'hDEAD_BEEF, 0);
        send_word(CMD_READ,   3,  32'h0, 0);

        while (issued < N_ITEMS) begin
            mode    = $urandom_range(MODE_FILL, MODE_MIXED);
            no_idle = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(20, 80);
            for (int k = 0; k < seg_len && issued < N_ITEMS; k++)
                random_request(mode);
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d rejected", issued, checked,
                 rejected);
        $display("longest list reached %0d of %0d entries", peak_len, CAPACITY);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #LIMIT_NS;
        $display("timeout with %0d results still pending", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
